[src/fcwc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcwc_pkg
// Shared types, constants and helpers of the front-coding word compressor.
// ----------------------------------------------------------------------------
package fcwc_pkg;

  // Character constants
  localparam logic [7:0] CHAR_ZERO    = 8'h30;  // '0'
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;  // 'z', top of the code alphabet
  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

  // Largest value the code alphabet can express
  localparam int unsigned CODE_TOP = 61;

  // Depth of the queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // One classified byte, handed from front to back
  typedef struct packed {
    logic [7:0] ch;
    logic       ch_valid;
    logic       word_end;
    logic       in_range;   // a compare against the previous word is allowed
    logic [7:0] prev_byte;  // previous word's byte at this position
    logic [7:0] code_at;    // code for this byte's position
    logic [7:0] code_end;   // code for the position after this byte
  } fcwc_item_t;

  // Map a shared length (0..61) to its code character
  function automatic logic [7:0] code_char(input logic [5:0] n);
    logic [5:0] v;
    v = (n > 6'(CODE_TOP)) ? 6'(CODE_TOP) : n;
    if (v < 6'd10) begin
      code_char = CHAR_ZERO + {2'b00, v};
    end else if (v < 6'd36) begin
      code_char = CHAR_UPPER_A + {2'b00, v - 6'd10};
    end else begin
      code_char = CHAR_LOWER_A + {2'b00, v - 6'd36};
    end
  endfunction

endpackage
`default_nettype wire

[src/front_coding_word_compressor.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// front_coding_word_compressor
// Front-codes a byte stream of words against the previous word.
// ----------------------------------------------------------------------------
//  Channel  Dir  tdata             tuser      tlast
//  s_axis   in   [7:0] ch          ch_valid   word_end
//  m_axis   out  [7:0] out_byte    -          line_last
//
//  Takes one input transaction per cycle while the queue has room; an item
//  gives 0 to 3 output bytes, and the back end issues one byte per cycle while
//  the sink is ready, so multi-byte items hold the back while a 4-entry
//  queue absorbs the front. Input reaches output via the word-store read, the
//  queue and output register. Reset clears position, previous length and the
//  match flag; the word store needs no clearing. Either side may stall freely.
// ----------------------------------------------------------------------------
module front_coding_word_compressor
  import fcwc_pkg::*;
#(
  parameter int unsigned WORD_MAX = 256,
  parameter int unsigned MAX_CODE = 61
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] ch
  input  wire logic       s_axis_tuser,   // [0] ch_valid
  input  wire logic       s_axis_tlast,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic            m_axis_tlast
);

  logic         item_valid;
  fcwc_item_t   item;
  logic         head_valid;
  fcwc_item_t   head_item;
  logic         pop;
  logic [QAW:0] q_level;

  // Accept and classify
  fcwc_front #(
    .WORD_MAX (WORD_MAX),
    .MAX_CODE (MAX_CODE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .ch         (s_axis_tdata),
    .ch_valid   (s_axis_tuser),
    .word_end   (s_axis_tlast),
    .q_level    (q_level),
    .item_valid (item_valid),
    .item       (item)
  );

  // Decouple front and back
  fcwc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (item_valid),
    .push_item  (item),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item),
    .level      (q_level)
  );

  // Resolve and emit
  fcwc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_byte   (m_axis_tdata),
    .line_last  (m_axis_tlast)
  );

endmodule
`default_nettype wire

[src/fcwc_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcwc_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
module fcwc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; a read at the written address returns old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

[src/fcwc_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcwc_front
// Accept bytes, track the position and previous length, store the word and
// fetch the previous word's byte for the back end's compare.
// ----------------------------------------------------------------------------
module fcwc_front
  import fcwc_pkg::*;
#(
  parameter int unsigned WORD_MAX = 256,
  parameter int unsigned MAX_CODE = 61
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       ch,
  input  wire logic             ch_valid,
  input  wire logic             word_end,
  input  wire logic [QAW:0]     q_level,
  output logic                  item_valid,
  output fcwc_item_t            item
);

  localparam int unsigned AW = $clog2(WORD_MAX);
  localparam int unsigned PW = $clog2(WORD_MAX + 1);
  localparam int unsigned CW = (PW > 6) ? PW : 6;

  logic [PW-1:0] position, position_next;
  logic [PW-1:0] prev_len;
  logic [PW-1:0] pos_after;
  logic          accept;
  logic          store;
  logic [CW-1:0] pos_wide, after_wide;
  logic [5:0]    cap_at, cap_end;
  logic [7:0]    rd_data;

  // Staged descriptor, joined with RAM read data in the cycle after acceptance
  logic       st_valid;
  logic [7:0] st_ch;
  logic       st_ch_valid;
  logic       st_word_end;
  logic       st_in_range;
  logic [7:0] st_code_at;
  logic [7:0] st_code_end;

  // Admit only while queue plus in-flight item leave a free slot
  assign in_ready = ({1'b0, q_level} + {{(QAW + 1){1'b0}}, st_valid}) <
                    (QAW + 2)'(QDEPTH);
  assign accept   = in_valid && in_ready;
  assign store    = ch_valid && (position < PW'(WORD_MAX));
  assign pos_after = store ? position + PW'(1) : position;

  // Cap positions for the code characters
  assign pos_wide   = CW'(position);
  assign after_wide = CW'(pos_after);
  assign cap_at  = (pos_wide > CW'(MAX_CODE)) ? 6'(MAX_CODE) : pos_wide[5:0];
  assign cap_end = (after_wide > CW'(MAX_CODE)) ? 6'(MAX_CODE) : after_wide[5:0];

  assign position_next = word_end ? '0 : pos_after;

  // Word store: write this byte, read the previous word's byte at the same slot
  fcwc_ram #(
    .WIDTH (8),
    .DEPTH (WORD_MAX)
  ) u_word_ram (
    .clk     (clk),
    .we      (accept && store),
    .wr_addr (position[AW-1:0]),
    .wr_data (ch),
    .rd_addr (position[AW-1:0]),
    .rd_data (rd_data)
  );

  // Advance position and previous length
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      prev_len <= '0;
    end else if (accept) begin
      position <= position_next;
      if (word_end) begin
        prev_len <= pos_after;
      end
    end
  end

  // Stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else begin
      st_valid <= accept;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      st_ch       <= ch;
      st_ch_valid <= ch_valid;
      st_word_end <= word_end;
      st_in_range <= (pos_wide < CW'(MAX_CODE)) && (position < prev_len);
      st_code_at  <= code_char(cap_at);
      st_code_end <= code_char(cap_end);
    end
  end

  // Hand the classified item to the queue
  assign item_valid     = st_valid;
  assign item.ch        = st_ch;
  assign item.ch_valid  = st_ch_valid;
  assign item.word_end  = st_word_end;
  assign item.in_range  = st_in_range;
  assign item.prev_byte = rd_data;
  assign item.code_at   = st_code_at;
  assign item.code_end  = st_code_end;

endmodule
`default_nettype wire

[src/fcwc_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcwc_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module fcwc_queue
  import fcwc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire fcwc_item_t  push_item,
  input  wire logic        pop,
  output logic             head_valid,
  output fcwc_item_t       head_item,
  output logic [QAW:0]     level
);

  fcwc_item_t     entries [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];
  assign level      = count;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (QAW + 1)'(1);
        2'b01:   count <= count - (QAW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

[src/fcwc_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcwc_back
// Resolve the prefix match, expand each item into its output bytes and
// drive them through an output register, one byte per cycle while the sink is ready.
// ----------------------------------------------------------------------------
module fcwc_back
  import fcwc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        head_valid,
  input  wire fcwc_item_t  head_item,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             line_last
);

  logic       still_matching, still_matching_next;
  logic [1:0] step, step_next;
  logic       match;
  logic       sm_mid;
  logic [1:0] n;
  logic [7:0] lst [3];
  logic       load;
  logic       final_step;
  logic [7:0] sel_byte;
  logic       sel_last;

  // Build the byte list of the head item
  always_comb begin
    lst[0] = '0;
    lst[1] = '0;
    lst[2] = '0;
    n      = 2'd0;
    match  = still_matching && head_item.in_range && (head_item.prev_byte == head_item.ch);
    sm_mid = head_item.ch_valid ? match : still_matching;
    if (head_item.ch_valid) begin
      if (still_matching && !match) begin
        lst[n] = head_item.code_at;
        n      = n + 2'd1;
        lst[n] = head_item.ch;
        n      = n + 2'd1;
      end else if (!still_matching) begin
        lst[n] = head_item.ch;
        n      = n + 2'd1;
      end
    end
    if (head_item.word_end) begin
      if (sm_mid) begin
        lst[n] = head_item.code_end;
        n      = n + 2'd1;
      end
      lst[n] = CHAR_NEWLINE;
      n      = n + 2'd1;
    end
  end

  // Step through the list
  assign final_step = (step == n - 2'd1);
  assign load       = head_valid && (n != 2'd0) && (!out_valid || out_ready);
  assign pop        = head_valid && ((n == 2'd0) || (load && final_step));
  assign sel_byte   = lst[step];
  assign sel_last   = head_item.word_end && final_step;

  always_comb begin
    step_next           = step;
    still_matching_next = still_matching;
    if (pop) begin
      step_next           = 2'd0;
      still_matching_next = head_item.word_end ? 1'b1 : sm_mid;
    end else if (load) begin
      step_next = step + 2'd1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      step           <= 2'd0;
      still_matching <= 1'b1;
      out_valid      <= 1'b0;
    end else begin
      step           <= step_next;
      still_matching <= still_matching_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte  <= sel_byte;
      line_last <= sel_last;
    end
  end

endmodule
`default_nettype wire
